/* hw/rtl/apc_pkg.sv */
// shared types and constants for the archive entry path checker
// no dependencies; used by apc_in_reg, apc_core and the top level
package apc_pkg;

  localparam logic [15:0] LENGTH_RESET = 16'd1024;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [1:0]  SEG_MAX      = 2'd3;

  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CTRL_LIMIT     = 8'h20;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
    logic       empty_name;
  } item_t;

  // segment that just ended is empty, "." or ".."
  function automatic logic seg_bad(input logic [1:0] seg_len, input logic only_dots);
    seg_bad = (seg_len == 2'd0) || (only_dots && (seg_len <= 2'd2));
  endfunction

endpackage

/* hw/rtl/apc_in_reg.sv */
// input register of the path checker: holds one request until the core takes it
// depends on apc_pkg
module apc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  apc_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output apc_pkg::item_t item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

/* hw/rtl/apc_core.sv */
// per-name rule tracking and verdict register of the path checker
// depends on apc_pkg
module apc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  apc_pkg::item_t item,
  input  logic [15:0]    max_length,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_safe
);

  logic [15:0] byte_count;
  logic [1:0]  segment_length;
  logic        segment_only_dots;
  logic        rule_broken;

  logic [15:0] byte_count_next;
  logic [1:0]  segment_length_next;
  logic        segment_only_dots_next;
  logic        rule_broken_next;
  logic        ends_name;
  logic        verdict_bad;

  assign ends_name = item.last_byte || item.empty_name;
  // an item that gives no verdict never waits on the output side
  assign advance = item_valid && (!ends_name || !out_valid || out_ready);

  always_comb begin
    byte_count_next        = byte_count;
    segment_length_next    = segment_length;
    segment_only_dots_next = segment_only_dots;
    rule_broken_next       = rule_broken;
    if (!item.empty_name) begin
      if ((byte_count == 16'd1) && (item.name_byte == apc_pkg::CHAR_COLON)) begin
        rule_broken_next = 1'b1;
      end
      if ((item.name_byte == apc_pkg::CHAR_BACKSLASH) ||
          (item.name_byte < apc_pkg::CTRL_LIMIT)) begin
        rule_broken_next = 1'b1;
      end
      if (item.name_byte == apc_pkg::CHAR_SLASH) begin
        if (apc_pkg::seg_bad(segment_length, segment_only_dots)) begin
          rule_broken_next = 1'b1;
        end
        segment_length_next    = 2'd0;
        segment_only_dots_next = 1'b1;
      end else begin
        if (segment_length != apc_pkg::SEG_MAX) begin
          segment_length_next = segment_length + 2'd1;
        end
        if (item.name_byte != apc_pkg::CHAR_DOT) begin
          segment_only_dots_next = 1'b0;
        end
      end
      if (byte_count != apc_pkg::COUNT_MAX) begin
        byte_count_next = byte_count + 16'd1;
      end
    end
    verdict_bad = rule_broken_next || (byte_count_next == 16'd0) ||
                  apc_pkg::seg_bad(segment_length_next, segment_only_dots_next) ||
                  (byte_count_next > max_length) ||
                  (byte_count_next == apc_pkg::COUNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= 16'd0;
      segment_length    <= 2'd0;
      segment_only_dots <= 1'b1;
      rule_broken       <= 1'b0;
    end else if (advance) begin
      if (ends_name) begin
        byte_count        <= 16'd0;
        segment_length    <= 2'd0;
        segment_only_dots <= 1'b1;
        rule_broken       <= 1'b0;
      end else begin
        byte_count        <= byte_count_next;
        segment_length    <= segment_length_next;
        segment_only_dots <= segment_only_dots_next;
        rule_broken       <= rule_broken_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ends_name) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ends_name) begin
      out_safe <= !verdict_bad;
    end
  end

endmodule

/* hw/rtl/archive_entry_path_checker.sv */
// Archive entry path checker, top level.
// Input stream: one name byte per request on s_axis; tlast marks the final
// byte, tuser marks a request that carries no byte and ends the name as is.
// Output stream: one verdict per name on m_axis, tdata[0] = safe.
// Configuration: cfg_wr_en/cfg_wr_data write max_length (reset 1024); write
// only while no name is in flight.
// Pipeline: two register stages (input register, then rule logic into the
// result register); the verdict is registered when the core takes the request
// that ends the name out of the input register.
// Throughput: one request per cycle while no stalled verdict holds the input; the
// rule logic is a single pass of byte compares and small counter updates per byte.
// A stalled verdict holds in the result register; bytes that end no name
// keep flowing past it, and the input stalls only when a second verdict
// meets a full result register.
// Reset (rst, synchronous) empties both registers, clears the per-name
// state and sets max_length to 1024; s_axis_tready is high right after.
// depends on apc_pkg, apc_in_reg, apc_core
module archive_entry_path_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] name_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // empty_name
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] safe, [7:1] zero
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0]    max_length;
  apc_pkg::item_t in_item;
  apc_pkg::item_t item;
  logic           item_valid;
  logic           advance;
  logic           safe;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= apc_pkg::LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  assign in_item.name_byte  = s_axis_tdata;
  assign in_item.last_byte  = s_axis_tlast;
  assign in_item.empty_name = s_axis_tuser;

  apc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  apc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .max_length (max_length),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_safe   (safe)
  );

  assign m_axis_tdata = {7'd0, safe};

endmodule

/* hw/rtl/apc_checker.sv */
// port-level checks for the archive entry path checker, bound to the top level
// depends on archive_entry_path_checker ports only
module apc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // both registers are empty after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("verdict valid right after reset");
  a_reset_in: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

  // a stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled verdict changed");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("verdict padding not zero");

  // a byte that ends no name is never held back by a full output
  a_pass: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast && !s_axis_tuser |=> s_axis_tready)
    else $error("input stalled behind a plain byte");

endmodule

bind archive_entry_path_checker apc_checker u_apc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
